>>> rtl/core/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
package qrs_pkg;

	localparam int OUT_BITS = 40;

	typedef enum logic [1:0] {
		KIND_DISTINCT = 2'd0,
		KIND_EQUAL    = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_NOT_QUAD = 2'd3
	} root_kind_t;

endpackage

>>> rtl/core/qrs_sqrt_cell.sv
// One bit step of the pipelined floor square root.
module qrs_sqrt_cell #(
	parameter int W = 33
) (
	input  logic           clk,
	input  logic [W+1:0]   rem_i,
	input  logic [W-1:0]   root_i,
	input  logic [2*W-1:0] rad_i,
	output logic [W+1:0]   rem_o,
	output logic [W-1:0]   root_o,
	output logic [2*W-1:0] rad_o
);

	logic [W+1:0] rem_sh;
	logic [W+1:0] trial;
	logic         ge;

	always_comb begin
		rem_sh = {rem_i[W-1:0], rad_i[2*W-1:2*W-2]};
		trial  = {root_i, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		rem_o  <= ge ? (rem_sh - trial) : rem_sh;
		root_o <= {root_i[W-2:0], ge};
		rad_o  <= rad_i << 2;
	end

endmodule

>>> rtl/core/qrs_div_cell.sv
// One quotient bit step of the pipelined restoring divider.
module qrs_div_cell #(
	parameter int NW = 34,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] nq_i,
	input  logic [DW-1:0] den_i,
	output logic [DW-1:0] rem_o,
	output logic [NW-1:0] nq_o
);

	logic [DW:0] t;
	logic [DW:0] diff;
	logic        ge;

	always_comb begin
		t    = {rem_i, nq_i[NW-1]};
		diff = t - {1'b0, den_i};
		ge   = t >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		rem_o <= ge ? diff[DW-1:0] : t[DW-1:0];
		nq_o  <= {nq_i[NW-2:0], ge};
	end

endmodule

>>> rtl/core/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: discriminant, square root and divider pipelines.
// A coefficient set is taken on every cycle in which start is high; busy is always low.
// Each set gives one result, shown for one cycle with done high. On its way a set passes
// through the product register, the discriminant register, the row of square-root
// cells, one per root bit, the numerator register, the row of divider cells, one per
// quotient bit, and the output register.
// Results leave in input order and cannot be held off by the receiver.
module quadratic_root_solver_unit #(
	parameter int COEF_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COEF_BITS-1:0]         coef_a,
	input  logic signed [COEF_BITS-1:0]         coef_b,
	input  logic signed [COEF_BITS-1:0]         coef_c,
	output logic                                done,
	output logic [1:0]                          root_kind,
	output logic signed [qrs_pkg::OUT_BITS-1:0] first_value,
	output logic signed [qrs_pkg::OUT_BITS-1:0] second_value
);

	import qrs_pkg::*;

	localparam int CW  = COEF_BITS;
	localparam int SW  = CW + FRAC_BITS + 1;
	localparam int DMW = 2 * CW + 1;
	localparam int NBW = CW + FRAC_BITS + 1;
	localparam int NSW = CW + FRAC_BITS + 3;
	localparam int NW  = CW + FRAC_BITS + 2;
	localparam int DW  = CW + 1;
	localparam int QX  = (NW > OUT_BITS + 1) ? NW : OUT_BITS + 1;
	localparam int SQS = 2 + 1 + NBW + DW;
	localparam int DVS = 2 + 1 + 1 + DW;
	localparam logic [QX-1:0] MAXPOS = QX'((64'd1 << (OUT_BITS - 1)) - 64'd1);
	localparam logic [QX-1:0] MAXNEG = QX'(64'd1 << (OUT_BITS - 1));

	logic [CW-1:0]         am, bm, cm;
	logic signed [CW:0]    negb;
	logic [2*CW-1:0]       bsq_s1, acm_s1;
	logic                  mixed_s1, azero_s1, aneg_s1, valid_s1;
	logic signed [NBW-1:0] nb_s1;
	logic [DW-1:0]         den_s1;

	logic [2*CW+1:0]       fac, bsqx;
	logic [DMW-1:0]        d_c;
	logic                  dneg_c;
	root_kind_t            kind_c;
	logic [DMW-1:0]        d_s2;
	root_kind_t            kind_s2;
	logic                  aneg_s2, valid_s2;
	logic signed [NBW-1:0] nb_s2;
	logic [DW-1:0]         den_s2;

	logic [SW+1:0]   sq_rem  [0:SW];
	logic [SW-1:0]   sq_root [0:SW];
	logic [2*SW-1:0] sq_rad  [0:SW];
	logic [SQS-1:0]  sq_side [0:SW];
	logic            sq_vld  [0:SW];

	root_kind_t            kind_e;
	logic                  aneg_e;
	logic signed [NBW-1:0] nb_e;
	logic [DW-1:0]         den_e;
	logic signed [NSW-1:0] sx, nbx, n1, n2;
	logic [NW-1:0]         m1_s3, m2_s3;
	logic [DVS-1:0]        side_s3;
	logic                  valid_s3;

	logic [DW-1:0]  dv_rem1 [0:NW];
	logic [DW-1:0]  dv_rem2 [0:NW];
	logic [NW-1:0]  dv_nq1  [0:NW];
	logic [NW-1:0]  dv_nq2  [0:NW];
	logic [DVS-1:0] dv_side [0:NW];
	logic           dv_vld  [0:NW];

	root_kind_t kind_f;
	logic       neg1_f, neg2_f;

	function automatic logic [OUT_BITS-1:0] sat_val(input logic [NW-1:0] q, input logic neg);
		logic [QX-1:0] qx;
		logic [QX-1:0] nq;
		qx = QX'(q);
		nq = -qx;
		if (neg) begin
			sat_val = (qx > MAXNEG) ? MAXNEG[OUT_BITS-1:0] : nq[OUT_BITS-1:0];
		end else begin
			sat_val = (qx > MAXPOS) ? MAXPOS[OUT_BITS-1:0] : qx[OUT_BITS-1:0];
		end
	endfunction

	assign busy = 1'b0;

	always_comb begin
		am   = coef_a[CW-1] ? (~coef_a + 1'b1) : coef_a;
		bm   = coef_b[CW-1] ? (~coef_b + 1'b1) : coef_b;
		cm   = coef_c[CW-1] ? (~coef_c + 1'b1) : coef_c;
		negb = -{coef_b[CW-1], coef_b};
	end

	always_ff @(posedge clk) begin
		bsq_s1   <= bm * bm;
		acm_s1   <= am * cm;
		mixed_s1 <= (coef_a[CW-1] != coef_c[CW-1]) && (coef_c != '0);
		azero_s1 <= coef_a == '0;
		aneg_s1  <= coef_a[CW-1];
		nb_s1    <= NBW'(negb) <<< FRAC_BITS;
		den_s1   <= {am, 1'b0};
	end

	always_comb begin
		fac    = {acm_s1, 2'b00};
		bsqx   = (2 * CW + 2)'(bsq_s1);
		dneg_c = 1'b0;
		if (mixed_s1) begin
			d_c = DMW'(bsqx + fac);
		end else if (fac <= bsqx) begin
			d_c = DMW'(bsqx - fac);
		end else begin
			d_c    = DMW'(fac - bsqx);
			dneg_c = 1'b1;
		end
		if (azero_s1) begin
			kind_c = KIND_NOT_QUAD;
		end else if (d_c == '0) begin
			kind_c = KIND_EQUAL;
		end else if (dneg_c) begin
			kind_c = KIND_COMPLEX;
		end else begin
			kind_c = KIND_DISTINCT;
		end
	end

	always_ff @(posedge clk) begin
		d_s2    <= d_c;
		kind_s2 <= kind_c;
		aneg_s2 <= aneg_s1;
		nb_s2   <= nb_s1;
		den_s2  <= den_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = (2 * SW)'(d_s2) << (2 * FRAC_BITS);
	assign sq_side[0] = {kind_s2, aneg_s2, nb_s2, den_s2};
	assign sq_vld[0]  = valid_s2;

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		qrs_sqrt_cell #(.W(SW)) u_cell (
			.clk    (clk),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.rad_i  (sq_rad[k]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1]),
			.rad_o  (sq_rad[k+1])
		);

		always_ff @(posedge clk) begin
			sq_side[k+1] <= sq_side[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end
	end

	always_comb begin
		kind_e = root_kind_t'(sq_side[SW][SQS-1:SQS-2]);
		aneg_e = sq_side[SW][SQS-3];
		nb_e   = sq_side[SW][DW+NBW-1:DW];
		den_e  = sq_side[SW][DW-1:0];
		sx     = $signed({2'b00, sq_root[SW]});
		nbx    = NSW'(nb_e);
		case (kind_e)
			KIND_DISTINCT: begin
				n1 = nbx + sx;
				n2 = nbx - sx;
			end
			KIND_EQUAL: begin
				n1 = nbx;
				n2 = nbx;
			end
			KIND_COMPLEX: begin
				n1 = nbx;
				n2 = sx;
			end
			default: begin
				n1 = '0;
				n2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		m1_s3   <= n1[NSW-1] ? NW'(-n1) : NW'(n1);
		m2_s3   <= n2[NSW-1] ? NW'(-n2) : NW'(n2);
		side_s3 <= {kind_e, n1[NSW-1] ^ aneg_e, n2[NSW-1] ^ aneg_e, den_e};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= sq_vld[SW];
		end
	end

	assign dv_rem1[0] = '0;
	assign dv_rem2[0] = '0;
	assign dv_nq1[0]  = m1_s3;
	assign dv_nq2[0]  = m2_s3;
	assign dv_side[0] = side_s3;
	assign dv_vld[0]  = valid_s3;

	for (genvar k = 0; k < NW; k++) begin : g_div
		qrs_div_cell #(.NW(NW), .DW(DW)) u_lane1 (
			.clk   (clk),
			.rem_i (dv_rem1[k]),
			.nq_i  (dv_nq1[k]),
			.den_i (dv_side[k][DW-1:0]),
			.rem_o (dv_rem1[k+1]),
			.nq_o  (dv_nq1[k+1])
		);

		qrs_div_cell #(.NW(NW), .DW(DW)) u_lane2 (
			.clk   (clk),
			.rem_i (dv_rem2[k]),
			.nq_i  (dv_nq2[k]),
			.den_i (dv_side[k][DW-1:0]),
			.rem_o (dv_rem2[k+1]),
			.nq_o  (dv_nq2[k+1])
		);

		always_ff @(posedge clk) begin
			dv_side[k+1] <= dv_side[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k+1] <= 1'b0;
			end else begin
				dv_vld[k+1] <= dv_vld[k];
			end
		end
	end

	always_comb begin
		kind_f = root_kind_t'(dv_side[NW][DVS-1:DVS-2]);
		neg1_f = dv_side[NW][DW+1];
		neg2_f = dv_side[NW][DW];
	end

	always_ff @(posedge clk) begin
		root_kind <= kind_f;
		if (kind_f == KIND_NOT_QUAD) begin
			first_value  <= '0;
			second_value <= '0;
		end else begin
			first_value  <= sat_val(dv_nq1[NW], neg1_f);
			second_value <= sat_val(dv_nq2[NW], neg2_f);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld[NW];
		end
	end

endmodule
